FILE: rtl/mstt_pkg.sv
`default_nettype none

package mstt_pkg;

    localparam int TIMER_SLOTS_DEF = 8;
    localparam int MAX_RESULTS     = 8;
    localparam int MODE_W          = 2;
    localparam int HANDLE_W        = 15;
    localparam int COUNT_W         = 16;

    localparam logic [MODE_W-1:0] MODE_SET  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STOP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;

    typedef enum logic [1:0] {
        OP_SET,
        OP_STOP,
        OP_TICK
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [HANDLE_W-1:0] handle;
        logic [COUNT_W-1:0]  amount;
    } in_item_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] expired_handle;
        logic                last;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
        op_t  op;
    } dp_cmd_t;

    typedef struct packed {
        logic last_issue;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/mstt_ram.sv
`default_nettype none

module mstt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/mstt_ctrl.sv
`default_nettype none

module mstt_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire mstt_pkg::in_item_t request,
    input  wire mstt_pkg::dp_stat_t stat,
    output logic                    busy,
    output mstt_pkg::dp_cmd_t       cmd
);

    import mstt_pkg::*;

    state_t state_reg;
    state_t state_next;
    op_t    req_op;
    logic   req_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        case (request.mode)
            MODE_SET:
            begin
                req_op = OP_SET;
                req_ok = (request.handle != '0);
            end
            MODE_STOP:
            begin
                req_op = OP_STOP;
                req_ok = (request.handle != '0);
            end
            MODE_TICK:
            begin
                req_op = OP_TICK;
                req_ok = 1'b1;
            end
            default:
            begin
                req_op = OP_TICK;
                req_ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.op     = req_op;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && req_ok)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

FILE: rtl/mstt_dp.sv
`default_nettype none

module mstt_dp #(
    parameter int TIMER_SLOTS = mstt_pkg::TIMER_SLOTS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mstt_pkg::in_item_t request,
    input  wire mstt_pkg::dp_cmd_t  cmd,
    output mstt_pkg::dp_stat_t      stat,
    output logic                    strobe,
    output mstt_pkg::out_item_t     result
);

    import mstt_pkg::*;

    localparam int IDX_W  = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int NW     = $clog2(MAX_RESULTS + 1);
    localparam int WORD_W = HANDLE_W + COUNT_W;

    op_t                    op_reg,          op_next;
    logic [HANDLE_W-1:0]    handle_reg,      handle_next;
    logic [COUNT_W-1:0]     amount_reg,      amount_next;
    logic [IDX_W-1:0]       cnt_reg,         cnt_next;
    logic                   proc_valid_reg,  proc_valid_next;
    logic [IDX_W-1:0]       proc_idx_reg,    proc_idx_next;
    logic [TIMER_SLOTS-1:0] valid_reg,       valid_next;
    logic [TIMER_SLOTS-1:0] fresh_reg,       fresh_next;
    logic                   placed_reg,      placed_next;
    logic                   pend_valid_reg,  pend_valid_next;
    logic [HANDLE_W-1:0]    pend_handle_reg, pend_handle_next;
    logic [NW-1:0]          n_reg,           n_next;
    logic                   strobe_reg,      strobe_next;
    out_item_t              result_reg,      result_next;

    logic                we;
    logic [WORD_W-1:0]   wdata;
    logic [WORD_W-1:0]   rdata;
    logic [HANDLE_W-1:0] rd_owner;
    logic [COUNT_W-1:0]  rd_rem;
    logic [COUNT_W-1:0]  new_rem;
    logic                slot_valid;
    logic                slot_fresh;
    logic                match;

    mstt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TIMER_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (proc_idx_reg),
        .wdata (wdata),
        .raddr (cnt_reg),
        .rdata (rdata)
    );

    assign rd_owner   = rdata[WORD_W-1:COUNT_W];
    assign rd_rem     = rdata[COUNT_W-1:0];
    assign slot_valid = valid_reg[proc_idx_reg];
    assign slot_fresh = fresh_reg[proc_idx_reg];
    assign match      = slot_valid && (rd_owner == handle_reg);
    assign new_rem    = (rd_rem > amount_reg) ? (rd_rem - amount_reg) : '0;

    assign stat.last_issue = (cnt_reg == IDX_W'(TIMER_SLOTS - 1));

    always_comb
    begin
        op_next          = op_reg;
        handle_next      = handle_reg;
        amount_next      = amount_reg;
        cnt_next         = cnt_reg;
        proc_valid_next  = cmd.scan;
        proc_idx_next    = cnt_reg;
        valid_next       = valid_reg;
        fresh_next       = fresh_reg;
        placed_next      = placed_reg;
        pend_valid_next  = pend_valid_reg;
        pend_handle_next = pend_handle_reg;
        n_next           = n_reg;
        strobe_next      = 1'b0;
        result_next      = result_reg;
        we               = 1'b0;
        wdata            = rdata;

        if (cmd.load)
        begin
            op_next         = cmd.op;
            handle_next     = request.handle;
            amount_next     = request.amount;
            cnt_next        = '0;
            placed_next     = 1'b0;
            pend_valid_next = 1'b0;
            n_next          = '0;
        end

        if (cmd.scan)
        begin
            cnt_next = cnt_reg + 1'b1;
        end

        if (proc_valid_reg)
        begin
            case (op_reg)
                OP_SET:
                begin
                    if ((!slot_valid || match) && !placed_reg)
                    begin
                        we                       = 1'b1;
                        wdata                    = {handle_reg, amount_reg};
                        valid_next[proc_idx_reg] = 1'b1;
                        fresh_next[proc_idx_reg] = 1'b1;
                        placed_next              = 1'b1;
                    end
                    else if (match)
                    begin
                        valid_next[proc_idx_reg] = 1'b0;
                        fresh_next[proc_idx_reg] = 1'b0;
                    end
                end
                OP_STOP:
                begin
                    if (match)
                    begin
                        valid_next[proc_idx_reg] = 1'b0;
                        fresh_next[proc_idx_reg] = 1'b0;
                    end
                end
                OP_TICK:
                begin
                    if (slot_valid && !slot_fresh)
                    begin
                        we    = 1'b1;
                        wdata = {rd_owner, new_rem};
                        if ((new_rem == '0) && (n_reg < NW'(MAX_RESULTS)))
                        begin
                            valid_next[proc_idx_reg] = 1'b0;
                            n_next                   = n_reg + 1'b1;
                            pend_valid_next          = 1'b1;
                            pend_handle_next         = rd_owner;
                            if (pend_valid_reg)
                            begin
                                strobe_next = 1'b1;
                                result_next = '{expired_handle: pend_handle_reg,
                                                last: 1'b0};
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.finish)
        begin
            if (op_reg == OP_TICK)
            begin
                fresh_next = '0;
            end
            if (pend_valid_reg)
            begin
                strobe_next     = 1'b1;
                result_next     = '{expired_handle: pend_handle_reg, last: 1'b1};
                pend_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            proc_valid_reg <= 1'b0;
            valid_reg      <= '0;
            fresh_reg      <= '0;
            placed_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            n_reg          <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            cnt_reg        <= cnt_next;
            proc_valid_reg <= proc_valid_next;
            valid_reg      <= valid_next;
            fresh_reg      <= fresh_next;
            placed_reg     <= placed_next;
            pend_valid_reg <= pend_valid_next;
            n_reg          <= n_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        handle_reg      <= handle_next;
        amount_reg      <= amount_next;
        proc_idx_reg    <= proc_idx_next;
        pend_handle_reg <= pend_handle_next;
        result_reg      <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

FILE: rtl/multi_slot_timer_table.sv
`default_nettype none

// Table of timer slots keyed by a nonzero handle.
// Request channel: drive request (mode, handle, amount) with start; the
// transfer happens at a clock edge where start is high and busy is low.
// Set, stop and tick each sweep the slot memory one slot per cycle, as
// the single memory read port allows; busy stays high through the sweep
// and the drain and finish states after it. A request with handle 0 on
// set or stop, or an unused mode, is taken and dropped; busy stays low.
// Result channel: each expiry of a tick appears on result for one cycle
// with strobe high, in slot order; last marks the final one of the tick.
// Each result is held back until the next expiry is found or the sweep
// ends; the final one arrives in the first cycle with busy low again.
// At most MAX_RESULTS expiries are reported per tick. The receiver
// cannot stall; every strobe is one transfer. Reset empties every slot
// at once through per-slot valid bits; no clearing pass is needed.
module multi_slot_timer_table #(
    parameter int TIMER_SLOTS = mstt_pkg::TIMER_SLOTS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire mstt_pkg::in_item_t  request,
    output logic                     strobe,
    output mstt_pkg::out_item_t      result
);

    import mstt_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    mstt_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .stat    (stat),
        .busy    (busy),
        .cmd     (cmd)
    );

    mstt_dp #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .strobe  (strobe),
        .result  (result)
    );

endmodule

`default_nettype wire

FILE: rtl/mstt_checker.sv
`default_nettype none

module mstt_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                strobe,
    input wire mstt_pkg::out_item_t result
);

    import mstt_pkg::*;

    a_handle_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (result.expired_handle != '0))
        else $error("expiry transfer with handle zero");

    a_quiet_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !strobe)
        else $error("result right after a request transfer");

    a_more_means_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !result.last) |-> busy)
        else $error("non-final result while idle");

    a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.last) |=> !strobe)
        else $error("result after the final one of a tick");

endmodule

bind multi_slot_timer_table mstt_checker u_mstt_checker (.*);

`default_nettype wire

FILE: bench/timer_expiry_checker.sv
module timer_expiry_checker #(
    parameter int TIMER_SLOTS = mstt_pkg::TIMER_SLOTS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                busy,
    input  wire mstt_pkg::in_item_t  request,
    input  wire logic                strobe,
    input  wire mstt_pkg::out_item_t result,
    output int                       errors,
    output int                       pending
);

    timeunit 1ns;
    timeprecision 1ps;

    import mstt_pkg::*;

    logic [HANDLE_W-1:0] slot_handle [TIMER_SLOTS];
    logic [COUNT_W-1:0]  slot_count  [TIMER_SLOTS];
    logic                slot_new    [TIMER_SLOTS];

    out_item_t expiry_q[$];

    function automatic void free_slot_of(input logic [HANDLE_W-1:0] h);
        for (int i = 0; i < TIMER_SLOTS; i++)
        begin
            if (slot_handle[i] == h)
            begin
                slot_handle[i] = '0;
                slot_count[i]  = '0;
                slot_new[i]    = 1'b0;
                return;
            end
        end
    endfunction

    function automatic void advance_timer_table(input in_item_t it);
        out_item_t batch[$];
        out_item_t e;
        bit        placed;
        int        n;
        n = 0;
        placed = 0;
        case (it.mode)
            MODE_SET:
            begin
                if (it.handle != '0)
                begin
                    free_slot_of(it.handle);
                    for (int i = 0; i < TIMER_SLOTS; i++)
                    begin
                        if (!placed && slot_handle[i] == '0)
                        begin
                            slot_handle[i] = it.handle;
                            slot_count[i]  = it.amount;
                            slot_new[i]    = 1'b1;
                            placed = 1;
                        end
                    end
                end
            end
            MODE_STOP:
            begin
                if (it.handle != '0)
                    free_slot_of(it.handle);
            end
            MODE_TICK:
            begin
                for (int i = 0; i < TIMER_SLOTS; i++)
                begin
                    if (slot_handle[i] != '0 && !slot_new[i])
                    begin
                        if (slot_count[i] > it.amount)
                            slot_count[i] = slot_count[i] - it.amount;
                        else
                            slot_count[i] = '0;
                        if (slot_count[i] == '0 && n < MAX_RESULTS)
                        begin
                            e.expired_handle = slot_handle[i];
                            e.last           = 1'b0;
                            batch.push_back(e);
                            slot_handle[i] = '0;
                            n++;
                        end
                    end
                end
                for (int i = 0; i < TIMER_SLOTS; i++)
                    slot_new[i] = 1'b0;
                for (int k = 0; k < batch.size(); k++)
                begin
                    e = batch[k];
                    e.last = (k == batch.size() - 1);
                    expiry_q.push_back(e);
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TIMER_SLOTS; i++)
            begin
                slot_handle[i] = '0;
                slot_count[i]  = '0;
                slot_new[i]    = 1'b0;
            end
            expiry_q.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            // compare before predicting: a transfer in this cycle cannot produce a result yet
            if (strobe === 1'b1)
            begin
                if (expiry_q.size() == 0)
                begin
                    $display("%0t: unexpected expiry: expected none, actual handle %0d last %0b",
                             $time, result.expired_handle, result.last);
                    errors++;
                end
                else
                begin
                    want = expiry_q.pop_front();
                    if (result.expired_handle !== want.expired_handle)
                    begin
                        $display("%0t: expired_handle mismatch: expected %0d, actual %0d",
                                 $time, want.expired_handle, result.expired_handle);
                        errors++;
                    end
                    if (result.last !== want.last)
                    begin
                        $display("%0t: last mismatch on handle %0d: expected %0b, actual %0b",
                                 $time, want.expired_handle, want.last, result.last);
                        errors++;
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                advance_timer_table(request);
            pending = expiry_q.size();
        end
    end

endmodule

FILE: bench/testbench.sv
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import mstt_pkg::*;

    localparam int                SLOTS       = TIMER_SLOTS_DEF;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int                CYCLE_LIMIT = 200000;
    localparam int                DRAIN_WAIT  = 2 * SLOTS + 8;
    localparam int                PHASE_ITEMS = 75;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_item_t  request;
    logic      strobe;
    out_item_t result;
    int        errors;
    int        pending;
    int        cycles = 0;
    int        idle_pct;

    multi_slot_timer_table #(
        .TIMER_SLOTS(SLOTS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .request(request),
        .strobe (strobe),
        .result (result)
    );

    timer_expiry_checker #(
        .TIMER_SLOTS(SLOTS)
    ) checker_i (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .request(request),
        .strobe (strobe),
        .result (result),
        .errors (errors),
        .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic in_item_t make_item(input logic [MODE_W-1:0] m,
                                           input int h, input int a);
        in_item_t it;
        it.mode   = m;
        it.handle = h[HANDLE_W-1:0];
        it.amount = a[COUNT_W-1:0];
        return it;
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_request(input in_item_t it);
        int gap;
        gap = 0;
        if ($urandom_range(99) < idle_pct)
            gap = $urandom_range(1, 5);
        repeat (gap)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start   <= 1'b1;
        request <= it;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    function automatic in_item_t random_request();
        in_item_t it;
        int       pick;
        int       sel;
        sel = $urandom_range(99);
        pick = $urandom_range(99);
        if (pick < 70)
            it.handle = HANDLE_W'($urandom_range(1, 12));
        else if (pick < 75)
            it.handle = '0;
        else
            it.handle = HANDLE_W'($urandom());
        pick = $urandom_range(99);
        if (sel < 40)
        begin
            it.mode = MODE_SET;
            if (pick < 60)
                it.amount = COUNT_W'($urandom_range(0, 15));
            else if (pick < 85)
                it.amount = COUNT_W'($urandom_range(0, 1000));
            else
                it.amount = COUNT_W'($urandom());
        end
        else if (sel < 55)
        begin
            it.mode   = MODE_STOP;
            it.amount = COUNT_W'($urandom());
        end
        else if (sel < 93)
        begin
            it.mode = MODE_TICK;
            if (pick < 60)
                it.amount = COUNT_W'($urandom_range(0, 8));
            else if (pick < 85)
                it.amount = COUNT_W'($urandom_range(0, 300));
            else
                it.amount = COUNT_W'($urandom());
        end
        else
        begin
            it.mode   = MODE_UNUSED;
            it.amount = COUNT_W'($urandom());
        end
        return it;
    endfunction

    initial
    begin
        int phase_idle [4];
        phase_idle = '{0, 71, 30, 0};
        idle_pct = 0;
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_request(make_item(MODE_TICK, 0, 0));
        send_request(make_item(MODE_SET, 0, 5));
        send_request(make_item(MODE_STOP, 0, 0));
        send_request(make_item(MODE_UNUSED, 32767, 65535));
        send_request(make_item(MODE_SET, 1, 0));
        send_request(make_item(MODE_TICK, 0, 65535));
        send_request(make_item(MODE_TICK, 0, 0));
        send_request(make_item(MODE_SET, 32767, 65535));
        send_request(make_item(MODE_SET, 2, 0));
        send_request(make_item(MODE_SET, 3, 1));
        send_request(make_item(MODE_SET, 4, 32768));
        send_request(make_item(MODE_SET, 5, 7));
        send_request(make_item(MODE_SET, 6, 100));
        send_request(make_item(MODE_SET, 7, 21845));
        send_request(make_item(MODE_SET, 8, 43690));
        send_request(make_item(MODE_SET, 100, 9));
        send_request(make_item(MODE_SET, 3, 10));
        send_request(make_item(MODE_STOP, 500, 0));
        send_request(make_item(MODE_TICK, 0, 1));
        send_request(make_item(MODE_TICK, 0, 65535));
        send_request(make_item(MODE_SET, 9, 3));
        send_request(make_item(MODE_STOP, 9, 0));
        send_request(make_item(MODE_SET, 9, 3));
        send_request(make_item(MODE_TICK, 0, 0));
        send_request(make_item(MODE_TICK, 16384, 5));

        for (int p = 0; p < 4; p++)
        begin
            idle_pct = phase_idle[p];
            repeat (PHASE_ITEMS) send_request(random_request());
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
